[rtl/core/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants for the table search engine: table geometry,
// mode codes, the input and result transaction types and the table access
// request.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KEY_W  = 32;
  localparam int IDX_W  = 10;
  // bisection bounds: signed, reach -1 and DEPTH
  localparam int BND_W  = ADDR_W + 2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_SEQ   = 2'd1;
  localparam logic [1:0] MODE_BIN   = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [KEY_W-1:0] key_value;
    logic [IDX_W-1:0]        write_index;
    logic [IDX_W-1:0]        range_low;
    logic [IDX_W-1:0]        range_high;
  } tse_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } tse_out_t;

  typedef struct packed {
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic signed [KEY_W-1:0] wdata;
    logic                    re;
    logic [ADDR_W-1:0]       raddr;
  } tse_mem_req_t;

endpackage

[rtl/core/table_search_engine.sv]
// ----------------------------------------------------------------------------
// table_search_engine
// Search engine over a table of signed 32-bit words: writes entries, scans a
// range linearly for the first match, or bisects a sorted range.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | tse_in_t  (mode, key, indexes)
//   out_    | output    | out_valid/out_stall | tse_out_t (found, position)
//
// One transaction at a time; the table port gives one read per cycle.
// Write, unused mode or empty range: the result is set on accept.
// Linear scan: one read per entry compared, up to 1024 entries.
// Bisection: about log2(range) reads, at most 11.
// Reset clears control only; the table holds no valid bits and needs no
// clearing pass. A result waits in the output register under out_stall
// while the next transaction is accepted and searched.
// ----------------------------------------------------------------------------
module table_search_engine
  import tse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tse_out_t out_data
);

  tse_mem_req_t            mem_req;
  logic signed [KEY_W-1:0] mem_rdata;
  logic                    res_valid;
  logic                    res_take;
  tse_out_t                res;

  logic     out_valid_r, out_valid_nxt;
  tse_out_t out_data_r;

  tse_ram u_ram (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result payload until taken
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/tse_ram.sv]
// ----------------------------------------------------------------------------
// tse_ram
// Table storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tse_ram
  import tse_pkg::*;
(
  input  logic                    clk,
  input  tse_mem_req_t            mem_req,
  output logic signed [KEY_W-1:0] mem_rdata
);

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rdata_r;

  // write one entry
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // read one entry, registered
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

[rtl/core/tse_ctrl.sv]
// ----------------------------------------------------------------------------
// tse_ctrl
// Search sequencer: takes one transaction at a time, writes the table or
// walks it with one read per cycle (linear scan or bisection), and holds
// the result until the output stage takes it.
// ----------------------------------------------------------------------------
module tse_ctrl
  import tse_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  tse_in_t                 in_data,
  output tse_mem_req_t            mem_req,
  input  logic signed [KEY_W-1:0] mem_rdata,
  output logic                    res_valid,
  input  logic                    res_take,
  output tse_out_t                res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEQ  = 2'd1;
  localparam logic [1:0] ST_BIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]              state_r,  state_nxt;
  logic signed [KEY_W-1:0] key_r,    key_nxt;
  logic [ADDR_W-1:0]       rlo_r,    rlo_nxt;
  logic [ADDR_W-1:0]       rhi_r,    rhi_nxt;
  logic [ADDR_W-1:0]       addr_r,   addr_nxt;
  logic signed [BND_W-1:0] bl_r,     bl_nxt;
  logic signed [BND_W-1:0] bh_r,     bh_nxt;
  tse_out_t                res_r,    res_nxt;

  logic [IDX_W-1:0]        hi_sat;
  logic                    in_acc;
  logic                    in_empty;
  logic [BND_W-1:0]        in_sum;
  logic                    hit;
  logic                    go_left;
  logic signed [BND_W-1:0] nl;
  logic signed [BND_W-1:0] nh;
  logic [BND_W-1:0]        nsum;

  // clamp the range end to the table
  assign hi_sat = ({1'b0, in_data.range_high} >= (IDX_W+1)'(DEPTH))
                  ? IDX_W'(DEPTH - 1) : in_data.range_high;
  assign in_empty = in_data.range_low > hi_sat;
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_sum   = BND_W'(in_data.range_low) + BND_W'(hi_sat);

  // bisection step on the returned entry
  assign hit     = (mem_rdata == key_r);
  assign go_left = (key_r < mem_rdata);
  assign nl      = go_left ? bl_r : $signed({2'b00, addr_r}) + BND_W'(1);
  assign nh      = go_left ? $signed({2'b00, addr_r}) - BND_W'(1) : bh_r;
  assign nsum    = $unsigned(nl) + $unsigned(nh);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    rlo_nxt       = rlo_r;
    rhi_nxt       = rhi_r;
    addr_nxt      = addr_r;
    bl_nxt        = bl_r;
    bh_nxt        = bh_r;
    res_nxt       = res_r;
    mem_req       = '0;
    mem_req.waddr = ADDR_W'(in_data.write_index);
    mem_req.wdata = in_data.key_value;
    mem_req.raddr = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt   = in_data.key_value;
          rlo_nxt   = ADDR_W'(in_data.range_low);
          rhi_nxt   = ADDR_W'(hi_sat);
          res_nxt   = '0;
          state_nxt = ST_DONE;
          case (in_data.mode)
            MODE_WRITE: begin
              mem_req.we = ({1'b0, in_data.write_index} < (IDX_W+1)'(DEPTH));
            end
            MODE_SEQ: begin
              if (!in_empty) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(in_data.range_low);
                addr_nxt      = ADDR_W'(in_data.range_low);
                state_nxt     = ST_SEQ;
              end
            end
            MODE_BIN: begin
              if (!in_empty) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_sum[ADDR_W:1];
                addr_nxt      = in_sum[ADDR_W:1];
                bl_nxt        = BND_W'(in_data.range_low);
                bh_nxt        = BND_W'(hi_sat);
                state_nxt     = ST_BIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEQ: begin
        // compare the entry read last cycle, fetch the next one
        if (hit) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = IDX_W'(addr_r);
          state_nxt        = ST_DONE;
        end else if (addr_r == rhi_r) begin
          state_nxt = ST_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = addr_r + ADDR_W'(1);
          addr_nxt      = addr_r + ADDR_W'(1);
        end
      end
      ST_BIN: begin
        // narrow the bounds, fetch the new middle
        if (hit) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = IDX_W'(addr_r);
          state_nxt        = ST_DONE;
        end else if (nl > nh) begin
          state_nxt = ST_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = nsum[ADDR_W:1];
          addr_nxt      = nsum[ADDR_W:1];
          bl_nxt        = nl;
          bh_nxt        = nh;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rlo_r  <= rlo_nxt;
    rhi_r  <= rhi_nxt;
    addr_r <= addr_nxt;
    bl_r   <= bl_nxt;
    bh_r   <= bh_nxt;
    res_r  <= res_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  // a reported hit lies inside the searched range
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_r.found) |->
      (ADDR_W'(res_r.position) >= rlo_r && ADDR_W'(res_r.position) <= rhi_r))
    else $error("hit position outside searched range");

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_r.found) |-> (res_r.position == '0))
    else $error("miss with nonzero position");

  // the scan index never leaves the range
  a_seq_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEQ) |-> (addr_r >= rlo_r && addr_r <= rhi_r))
    else $error("scan index outside range");

  // the bisection middle stays between its bounds
  a_bin_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIN) |->
      ($signed({2'b00, addr_r}) >= bl_r && $signed({2'b00, addr_r}) <= bh_r))
    else $error("bisection middle outside bounds");

  // a write transaction finishes at once with no hit
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.mode == MODE_WRITE) |=> (state_r == ST_DONE && !res_r.found))
    else $error("write transaction did not complete as a miss");
`endif

endmodule
